>>> sv/pbpm_pkg.sv
// Package for the packet buffer pool manager: sizes, codes, payload and control types.
`default_nettype none
package pbpm_pkg;

	// Pool geometry and buffer layout
	localparam int POOL_DEPTH   = 64;
	localparam int BUF_BYTES    = 2048;
	localparam int ALIGN_OFFSET = 2;
	localparam int MTU_BYTES    = 1500;
	localparam int SG_SLOTS     = 8;
	localparam int MAX_CHAIN    = 16;

	localparam int IDX_W  = $clog2(POOL_DEPTH);
	localparam int LINK_W = $clog2(POOL_DEPTH + 1);
	localparam int CNT_W  = 5;
	localparam int BYTE_W = 12;
	localparam int LEN_W  = 12;
	localparam int LIM_MAX = (MAX_CHAIN > SG_SLOTS) ? MAX_CHAIN : SG_SLOTS;
	localparam int LIM_W  = $clog2(LIM_MAX + 1);
	localparam int STEP_W = $clog2(POOL_DEPTH + 1);
	localparam int SPAN   = BUF_BYTES - ALIGN_OFFSET;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);

	typedef enum logic [2:0] {
		MODE_ALLOC_ONE   = 3'd0,
		MODE_ALLOC_CHAIN = 3'd1,
		MODE_ALLOC_SG    = 3'd2,
		MODE_FREE_ONE    = 3'd3,
		MODE_FREE_CHAIN  = 3'd4,
		MODE_TRIM        = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_ZERO  = 2'd2,
		ST_MTU   = 2'd3
	} status_t;

	typedef struct packed {
		mode_t              mode;
		logic [IDX_W-1:0]   buffer_index;
		logic [CNT_W-1:0]   request_count;
		logic [BYTE_W-1:0]  byte_count;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]   result_buffer;
		logic [LEN_W-1:0]   head_offset;
		logic [LEN_W-1:0]   data_length;
		logic               last_of_run;
		status_t            status;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_FREE1,
		S_G_RD,
		S_G_CHK,
		S_REL_RD,
		S_REL_CHK,
		S_T_RD,
		S_T_CHK,
		S_P_RD,
		S_P_CHK
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic rd_cur;
		logic chase;
		logic move_last;
		logic trim_null;
		logic wr_null;
		logic set_rest;
		logic rel_tail;
		logic free_one;
		logic grant_end;
		logic emit_grant;
		logic emit_err;
		logic emit_trim;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		mode_t req_mode;
		logic  req_err;
		logic  req_oob;
		logic  need_walk;
		logic  link_null;
		logic  grant_stop;
		logic  steps_done;
		logic  rem_small;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> sv/pbpm_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module pbpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and read one address per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

>>> sv/pbpm_dp.sv
// Datapath of the pool manager: link table, walk registers and result register.
`default_nettype none
module pbpm_dp import pbpm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  req_t         request,
	input  dp_cmd_t      cmd,
	output dp_stat_t     stat,
	output logic         result_valid,
	output res_t         result
);

	logic [LINK_W-1:0]     free_head_q;
	logic [LINK_W-1:0]     cur_q;
	logic [LINK_W-1:0]     rel_head_q;
	logic [IDX_W-1:0]      idx_q;
	mode_t                 mode_q;
	logic [LIM_W-1:0]      k_q;
	logic [LIM_W-1:0]      limit_q;
	logic [STEP_W-1:0]     steps_q;
	logic [BYTE_W-1:0]     rem_q;
	logic [LEN_W-1:0]      off_q;
	logic [LEN_W-1:0]      len_q;
	logic                  first_q;
	status_t               err_q;
	logic [IDX_W-1:0]      err_buf_q;
	logic [POOL_DEPTH-1:0] vld_q;
	logic [IDX_W-1:0]      ram_addr_s1;
	logic                  res_valid_q;
	res_t                  res_q;

	logic [IDX_W-1:0]      ram_addr;
	logic                  ram_we;
	logic [LINK_W-1:0]     ram_wdata;
	logic [LINK_W-1:0]     ram_rdata;
	logic [LINK_W-1:0]     link;
	logic                  fh_null;
	logic                  mtu_err;
	logic                  stop;
	logic [LIM_W-1:0]      req_limit;
	status_t               req_code;
	logic                  req_err;
	logic                  is_sg;

	pbpm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_DEPTH)) u_links (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// unwritten entries read as their reset link i+1
	assign link = vld_q[ram_addr_s1] ? ram_rdata : (LINK_W'(ram_addr_s1) + LINK_W'(1));

	// decode the live request
	assign fh_null = (free_head_q == NULL_LINK);
	assign mtu_err = (32'(request.byte_count) > MTU_BYTES);

	always_comb begin
		req_code = ST_OK;
		req_err = 1'b0;
		unique case (request.mode)
			MODE_ALLOC_ONE, MODE_ALLOC_SG: begin
				req_err = fh_null;
				req_code = ST_EMPTY;
			end
			MODE_ALLOC_CHAIN: begin
				req_err = fh_null || (request.request_count == '0);
				req_code = fh_null ? ST_EMPTY : ST_ZERO;
			end
			MODE_TRIM: begin
				req_err = mtu_err;
				req_code = ST_MTU;
			end
			default: begin
				req_err = 1'b0;
				req_code = ST_OK;
			end
		endcase
	end

	always_comb begin
		case (request.mode)
			MODE_ALLOC_CHAIN: req_limit = (32'(request.request_count) > MAX_CHAIN) ?
				LIM_W'(MAX_CHAIN) : LIM_W'(request.request_count);
			MODE_ALLOC_SG:    req_limit = LIM_W'(SG_SLOTS);
			default:          req_limit = LIM_W'(1);
		endcase
	end

	assign stop = ((LIM_W+1)'(k_q) + (LIM_W+1)'(1) >= (LIM_W+1)'(limit_q)) || (link == NULL_LINK);
	assign is_sg = (mode_q == MODE_ALLOC_SG);

	assign stat.req_mode   = request.mode;
	assign stat.req_err    = req_err;
	assign stat.req_oob    = (32'(request.buffer_index) >= POOL_DEPTH);
	assign stat.need_walk  = (32'(request.byte_count) > SPAN);
	assign stat.link_null  = (link == NULL_LINK);
	assign stat.grant_stop = stop;
	assign stat.steps_done = (32'(steps_q) >= POOL_DEPTH);
	assign stat.rem_small  = (32'(rem_q) < BUF_BYTES);

	// link table port
	always_comb begin
		if (cmd.chase) begin
			ram_addr = link[IDX_W-1:0];
		end else if (cmd.free_one) begin
			ram_addr = idx_q;
		end else begin
			ram_addr = cur_q[IDX_W-1:0];
		end
	end
	assign ram_we    = cmd.wr_null || cmd.rel_tail || cmd.free_one;
	assign ram_wdata = cmd.wr_null ? NULL_LINK : free_head_q;

	// track written entries and the read address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[ram_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		ram_addr_s1 <= ram_addr;
	end

	// free list head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
		end else if (cmd.grant_end) begin
			free_head_q <= link;
		end else if (cmd.rel_tail) begin
			free_head_q <= rel_head_q;
		end else if (cmd.free_one) begin
			free_head_q <= LINK_W'(idx_q);
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q    <= request.mode;
			idx_q     <= request.buffer_index;
			cur_q     <= (request.mode == MODE_ALLOC_ONE || request.mode == MODE_ALLOC_CHAIN ||
				request.mode == MODE_ALLOC_SG) ? free_head_q : LINK_W'(request.buffer_index);
			rel_head_q <= LINK_W'(request.buffer_index);
			k_q       <= '0;
			limit_q   <= req_limit;
			steps_q   <= '0;
			first_q   <= 1'b1;
			err_q     <= req_code;
			err_buf_q <= (request.mode == MODE_TRIM) ? request.buffer_index : '0;
			if (32'(request.byte_count) > SPAN) begin
				rem_q <= request.byte_count - BYTE_W'(SPAN);
				off_q <= '0;
			end else begin
				rem_q <= request.byte_count;
				off_q <= LEN_W'(ALIGN_OFFSET);
			end
			len_q <= LEN_W'(request.byte_count);
		end else if (cmd.chase) begin
			cur_q   <= link;
			k_q     <= k_q + LIM_W'(1);
			steps_q <= steps_q + STEP_W'(1);
			rem_q   <= rem_q - BYTE_W'(BUF_BYTES);
			first_q <= 1'b0;
		end else if (cmd.move_last) begin
			cur_q <= link;
			len_q <= LEN_W'(rem_q);
		end else if (cmd.trim_null) begin
			if (first_q) begin
				off_q <= LEN_W'(ALIGN_OFFSET);
				len_q <= LEN_W'(SPAN);
			end else begin
				len_q <= LEN_W'(BUF_BYTES);
			end
		end else if (cmd.set_rest) begin
			cur_q      <= link;
			rel_head_q <= link;
			steps_q    <= '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit_grant || cmd.emit_err || cmd.emit_trim;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_grant) begin
			res_q.result_buffer <= cur_q[IDX_W-1:0];
			res_q.head_offset   <= (is_sg && k_q == '0) ? LEN_W'(ALIGN_OFFSET) : '0;
			res_q.data_length   <= !is_sg ? '0 :
				((k_q == '0) ? LEN_W'(SPAN) : LEN_W'(BUF_BYTES));
			res_q.last_of_run   <= stop;
			res_q.status        <= ST_OK;
		end else if (cmd.emit_trim) begin
			res_q.result_buffer <= cur_q[IDX_W-1:0];
			res_q.head_offset   <= off_q;
			res_q.data_length   <= len_q;
			res_q.last_of_run   <= 1'b1;
			res_q.status        <= ST_OK;
		end else if (cmd.emit_err) begin
			res_q.result_buffer <= err_buf_q;
			res_q.head_offset   <= '0;
			res_q.data_length   <= '0;
			res_q.last_of_run   <= 1'b1;
			res_q.status        <= err_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	a_no_chase_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.chase |-> !ram_we) else $error("link chase collides with a table write");
	a_chase_not_null: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.chase |-> link != NULL_LINK) else $error("chase through a null link");
	a_single_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.emit_grant, cmd.emit_err, cmd.emit_trim}) <= 1)
		else $error("two results in one cycle");
`endif

endmodule
`default_nettype wire

>>> sv/pbpm_ctrl.sv
// Controller of the pool manager: sequences allocation, free and trim walks.
`default_nettype none
module pbpm_ctrl import pbpm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  dp_stat_t     stat,
	output dp_cmd_t      cmd,
	output logic         busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					case (stat.req_mode)
						MODE_ALLOC_ONE, MODE_ALLOC_CHAIN, MODE_ALLOC_SG:
							state_d = stat.req_err ? S_ERR : S_G_RD;
						MODE_FREE_ONE:
							state_d = stat.req_oob ? S_IDLE : S_FREE1;
						MODE_FREE_CHAIN:
							state_d = stat.req_oob ? S_IDLE : S_REL_RD;
						MODE_TRIM: begin
							if (stat.req_oob) begin
								state_d = S_IDLE;
							end else if (stat.req_err) begin
								state_d = S_ERR;
							end else begin
								state_d = stat.need_walk ? S_T_RD : S_P_RD;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ERR:     state_d = S_IDLE;
			S_FREE1:   state_d = S_IDLE;
			S_G_RD:    state_d = S_G_CHK;
			S_G_CHK:   state_d = stat.grant_stop ? S_IDLE : S_G_CHK;
			S_REL_RD:  state_d = S_REL_CHK;
			S_REL_CHK: state_d = (!stat.link_null && !stat.steps_done) ? S_REL_CHK : S_IDLE;
			S_T_RD:    state_d = S_T_CHK;
			S_T_CHK:   state_d = (stat.link_null || stat.rem_small) ? S_P_RD : S_T_CHK;
			S_P_RD:    state_d = S_P_CHK;
			S_P_CHK:   state_d = stat.link_null ? S_IDLE : S_REL_RD;
			default:   state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.capture = start;
			S_ERR:    cmd.emit_err = 1'b1;
			S_FREE1:  cmd.free_one = 1'b1;
			S_G_RD, S_REL_RD, S_T_RD, S_P_RD: cmd.rd_cur = 1'b1;
			S_G_CHK: begin
				cmd.emit_grant = 1'b1;
				if (stat.grant_stop) begin
					cmd.wr_null   = 1'b1;
					cmd.grant_end = 1'b1;
				end else begin
					cmd.chase = 1'b1;
				end
			end
			S_REL_CHK: begin
				if (!stat.link_null && !stat.steps_done) begin
					cmd.chase = 1'b1;
				end else begin
					cmd.rel_tail = 1'b1;
				end
			end
			S_T_CHK: begin
				if (stat.link_null) begin
					cmd.trim_null = 1'b1;
				end else if (stat.rem_small) begin
					cmd.move_last = 1'b1;
				end else begin
					cmd.chase = 1'b1;
				end
			end
			S_P_CHK: begin
				cmd.emit_trim = 1'b1;
				if (!stat.link_null) begin
					cmd.wr_null  = 1'b1;
					cmd.set_rest = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

>>> sv/packet_buffer_pool_manager.sv
// Top level of the packet buffer pool manager.
// A request is taken when start is high and busy low; busy then stays high until the
// request is done. Results appear one per cycle on result with result_valid high for one
// cycle and cannot be held off. The link table is walked one entry per cycle; free chain
// follows at most POOL_DEPTH links, and trim releases any remainder of the chain after
// the kept buffer (the MTU limit keeps the kept data within the first buffer, so trim
// never walks forward). No clearing pass after reset.
`default_nettype none
module packet_buffer_pool_manager import pbpm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  req_t      request,
	output logic      result_valid,
	output res_t      result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pbpm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	pbpm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.request     (request),
		.cmd         (cmd),
		.stat        (stat),
		.result_valid(result_valid),
		.result      (result)
	);

`ifndef SYNTHESIS
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result without a transaction in flight");
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_of_run |=> result_valid)
		else $error("gap inside a result run");
	a_free_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.mode == MODE_FREE_ONE |=> !result_valid ##1 !result_valid)
		else $error("free produced a result");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for the packet buffer pool manager: self-checking, directed and random transactions.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import pbpm_pkg::*;

	localparam logic [2:0] MODE_RSVD_6 = 3'd6;
	localparam logic [2:0] MODE_RSVD_7 = 3'd7;
	localparam int POOL_NULL = POOL_DEPTH;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic result_valid;
	res_t result;

	// Shadow copy of the pool
	int   pool_links[POOL_DEPTH];
	int   pool_head;
	res_t grants_due[$];
	int   held_heads[$];
	int   held_singles[$];
	int   mismatch_count;
	bit   use_gaps;

	packet_buffer_pool_manager dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Queue one expected result
	function automatic void push_grant(int buf_idx, int off, int len, bit last, status_t st);
		res_t r;
		r.result_buffer = buf_idx[IDX_W-1:0];
		r.head_offset   = off[LEN_W-1:0];
		r.data_length   = len[LEN_W-1:0];
		r.last_of_run   = last;
		r.status        = st;
		grants_due.push_back(r);
	endfunction

	// Return a chain to the free list; a looped chain stops after POOL_DEPTH steps
	function automatic void release_chain(int first);
		int cur;
		int steps;
		cur = first;
		steps = 0;
		while (pool_links[cur] != POOL_NULL && steps < POOL_DEPTH) begin
			cur = pool_links[cur];
			steps++;
		end
		pool_links[cur] = pool_head;
		pool_head = first;
	endfunction

	// Work out the results of one accepted transaction and update the shadow pool
	function automatic void predict_pool(req_t r);
		int limit, cur, k, off, len, span, nth, nx, rest;
		bit stop, is_sg;
		limit = 1;
		is_sg = (r.mode == MODE_ALLOC_SG);
		case (r.mode)
			MODE_ALLOC_ONE, MODE_ALLOC_CHAIN, MODE_ALLOC_SG: begin
				if (pool_head == POOL_NULL) begin
					push_grant(0, 0, 0, 1'b1, ST_EMPTY);
					return;
				end
				if (r.mode == MODE_ALLOC_CHAIN) begin
					if (r.request_count == 0) begin
						push_grant(0, 0, 0, 1'b1, ST_ZERO);
						return;
					end
					limit = (r.request_count > MAX_CHAIN) ? MAX_CHAIN : int'(r.request_count);
				end else if (is_sg) begin
					limit = SG_SLOTS;
				end
				cur = pool_head;
				k = 0;
				forever begin
					off = (is_sg && k == 0) ? ALIGN_OFFSET : 0;
					len = is_sg ? BUF_BYTES - off : 0;
					stop = (k + 1 >= limit) || pool_links[cur] == POOL_NULL;
					push_grant(cur, off, len, stop, ST_OK);
					k++;
					if (stop)
						break;
					cur = pool_links[cur];
				end
				pool_head = pool_links[cur];
				pool_links[cur] = POOL_NULL;
			end
			MODE_FREE_ONE: begin
				pool_links[r.buffer_index] = pool_head;
				pool_head = int'(r.buffer_index);
			end
			MODE_FREE_CHAIN: release_chain(int'(r.buffer_index));
			MODE_TRIM: begin
				if (r.byte_count > MTU_BYTES) begin
					push_grant(int'(r.buffer_index), 0, 0, 1'b1, ST_MTU);
					return;
				end
				cur = int'(r.buffer_index);
				off = ALIGN_OFFSET;
				len = int'(r.byte_count);
				span = BUF_BYTES - ALIGN_OFFSET;
				if (r.byte_count > span) begin
					len = int'(r.byte_count) - span;
					nth = len / BUF_BYTES;
					len -= nth * BUF_BYTES;
					off = 0;
					for (int j = 0; j <= nth; j++) begin
						nx = pool_links[cur];
						if (nx == POOL_NULL) begin
							if (j == 0) begin
								off = ALIGN_OFFSET;
								len = span;
							end else begin
								len = BUF_BYTES;
							end
							break;
						end
						cur = nx;
					end
				end
				if (pool_links[cur] != POOL_NULL) begin
					rest = pool_links[cur];
					pool_links[cur] = POOL_NULL;
					release_chain(rest);
				end
				push_grant(cur, off, len, 1'b1, ST_OK);
			end
			default: ;
		endcase
	endfunction

	// Idle for a random spell: mostly short, now and then long
	task automatic idle_gap();
		int pick, n;
		pick = $urandom_range(0, 99);
		n = !use_gaps ? 0 : (pick < 50) ? 0 : (pick < 90) ? $urandom_range(1, 3)
			: $urandom_range(10, 40);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Present one transaction and hold it until taken
	task automatic send_req(logic [2:0] mode, int idx, int cnt, int bytes);
		req_t r;
		r.mode          = mode_t'(mode);
		r.buffer_index  = idx[IDX_W-1:0];
		r.request_count = cnt[CNT_W-1:0];
		r.byte_count    = bytes[BYTE_W-1:0];
		@(negedge clk);
		request <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predict_pool(r);
		idle_gap();
	endtask

	// Allocate and remember the granted head for later frees and trims
	task automatic alloc_tracked(logic [2:0] mode, int cnt);
		int n_before;
		n_before = grants_due.size();
		send_req(mode, 0, cnt, 0);
		if (grants_due.size() > n_before && grants_due[n_before].status == ST_OK) begin
			if (mode == MODE_ALLOC_ONE)
				held_singles.push_back(int'(grants_due[n_before].result_buffer));
			else
				held_heads.push_back(int'(grants_due[n_before].result_buffer));
		end
	endtask

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && result_valid) begin
			if (grants_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result %p", result);
			end else begin
				want = grants_due.pop_front();
				if (result.result_buffer !== want.result_buffer ||
				    result.head_offset !== want.head_offset ||
				    result.data_length !== want.data_length ||
				    result.last_of_run !== want.last_of_run ||
				    result.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: expected %p, got %p", want, result);
				end
			end
		end
	end

	task automatic test_alloc_modes();
		use_gaps = 1'b0;
		alloc_tracked(MODE_ALLOC_ONE, 0);
		alloc_tracked(MODE_ALLOC_CHAIN, 0);
		alloc_tracked(MODE_ALLOC_CHAIN, 1);
		alloc_tracked(MODE_ALLOC_CHAIN, 16);
		alloc_tracked(MODE_ALLOC_CHAIN, 31);
		alloc_tracked(MODE_ALLOC_SG, 0);
		send_req(MODE_RSVD_6, 63, 31, 4095);
		send_req(MODE_RSVD_7, 0, 0, 0);
	endtask

	task automatic test_trim_cases();
		use_gaps = 1'b1;
		send_req(MODE_TRIM, held_heads[0], 0, 1501);
		send_req(MODE_TRIM, held_heads[0], 0, 4095);
		send_req(MODE_TRIM, held_heads[1], 0, 1500);
		send_req(MODE_TRIM, held_heads[2], 0, 0);
		send_req(MODE_TRIM, held_heads[3], 21, 1024);
	endtask

	// Drain the pool, then hit the empty cases, then give it back
	task automatic test_pool_dry();
		while (pool_head != POOL_NULL)
			alloc_tracked(MODE_ALLOC_CHAIN, 16);
		send_req(MODE_ALLOC_ONE, 0, 0, 0);
		send_req(MODE_ALLOC_CHAIN, 0, 5, 0);
		send_req(MODE_ALLOC_CHAIN, 0, 0, 0);
		send_req(MODE_ALLOC_SG, 0, 0, 0);
		while (held_heads.size() > 0)
			send_req(MODE_FREE_CHAIN, held_heads.pop_front(), 0, 0);
		while (held_singles.size() > 0)
			send_req(MODE_FREE_ONE, held_singles.pop_front(), 0, 0);
	endtask

	task automatic test_random_traffic();
		int pick, h;
		for (int i = 0; i < 180; i++) begin
			use_gaps = (i / 40) % 2 == 0;
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				// noise: any field value, possibly a double free
				send_req(3'($urandom_range(0, 7)), $urandom_range(0, 63), $urandom_range(0, 31),
					$urandom_range(0, 4095));
			end else if (pick < 45 || (held_heads.size() == 0 && held_singles.size() == 0)) begin
				alloc_tracked(3'($urandom_range(0, 2)), $urandom_range(0, 20));
			end else if (pick < 60 && held_singles.size() > 0) begin
				send_req(MODE_FREE_ONE, held_singles.pop_front(), 0, 0);
			end else if (held_heads.size() > 0 && pick < 80) begin
				send_req(MODE_FREE_CHAIN, held_heads.pop_front(), 0, 0);
			end else if (held_heads.size() > 0) begin
				h = held_heads[$urandom_range(0, held_heads.size() - 1)];
				send_req(MODE_TRIM, h, 0, ($urandom_range(0, 9) == 0) ?
					$urandom_range(1501, 4095) : $urandom_range(0, 1500));
			end else begin
				send_req(MODE_FREE_ONE, held_singles.pop_front(), 0, 0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		mismatch_count = 0;
		use_gaps = 1'b0;
		for (int i = 0; i < POOL_DEPTH; i++)
			pool_links[i] = i + 1;
		pool_head = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_alloc_modes();
		test_trim_cases();
		test_pool_dry();
		test_random_traffic();

		@(negedge clk);
		start <= 1'b0;
		@(posedge clk);
		while (grants_due.size() > 0 || busy)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && grants_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
